// File: design/lpm_pkg.sv
// Shared types and constants for the longest-prefix route lookup.
`timescale 1ns / 1ps
package lpm_pkg;
	localparam int ROUTE_SLOTS_DEF = 64;
	localparam int TAG_WIDTH_DEF   = 16;
	localparam int ADDR_W          = 128;
	localparam int PFX_W           = 8;
	localparam int OUT_TAG_W       = 16;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_LOOKUP   = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_NO_ROUTE = 3'd2;
	localparam logic [2:0] ST_REJECTED = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BAD_PFX  = 3'd5;
	localparam logic [2:0] ST_CLEARED  = 3'd6;

	localparam logic [3:0]  VER_IPV4     = 4'd4;
	localparam logic [3:0]  VER_IPV6     = 4'd6;
	localparam logic [15:0] IPV4_MIN_LEN = 16'd20;
	localparam logic [15:0] IPV6_MIN_LEN = 16'd40;
	localparam logic [7:0]  IPV4_MAX_PFX = 8'd32;
	localparam logic [7:0]  IPV6_MAX_PFX = 8'd128;

	typedef struct packed {
		logic [1:0]  operation;
		logic        addr_family;
		logic [3:0]  version;
		logic [15:0] packet_length;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  prefix_len;
		logic [15:0] eid_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] found_tag;
		logic [7:0]  found_prefix_len;
	} rsp_t;

	typedef struct packed {
		logic              family;
		logic [ADDR_W-1:0] addr;
	} query_t;

	typedef struct packed {
		logic              en;
		logic              family;
		logic [ADDR_W-1:0] addr;
		logic [PFX_W-1:0]  prefix;
	} write_t;

	typedef struct packed {
		logic             valid;
		logic             have;
		logic [PFX_W-1:0] prefix;
	} tok_t;
endpackage

// File: design/lpm_cell.sv
// One route slot: holds an entry and updates the passing best-match token.
`timescale 1ns / 1ps
module lpm_cell
	import lpm_pkg::*;
#(
	parameter int INDEX     = 0,
	parameter int CNT_W     = 7,
	parameter int IDX_W     = 6,
	parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     count,
	input  write_t               wr,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic [TAG_WIDTH-1:0] wr_tag,
	input  query_t               query,
	input  tok_t                 tok_in,
	input  logic [TAG_WIDTH-1:0] tag_in,
	output tok_t                 tok_out,
	output logic [TAG_WIDTH-1:0] tag_out
);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

	logic              family_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PFX_W-1:0]  prefix_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [ADDR_W-1:0] mask;
	logic              hit;
	logic              take;

	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == MY_IDX) begin
			family_q <= wr.family;
			addr_q   <= wr.addr;
			prefix_q <= wr.prefix;
			tag_q    <= wr_tag;
		end
	end

	always_comb begin
		for (int j = 0; j < ADDR_W; j++) begin
			mask[ADDR_W-1-j] = (PFX_W'(j) < prefix_q) || (prefix_q == IPV6_MAX_PFX);
		end
	end

	assign hit  = (MY_CNT < count) && (family_q == query.family) &&
		(((addr_q ^ query.addr) & mask) == '0);
	assign take = hit && (!tok_in.have || prefix_q > tok_in.prefix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
			tag_out <= '0;
		end else begin
			tok_out.valid  <= tok_in.valid;
			tok_out.have   <= tok_in.have || take;
			tok_out.prefix <= take ? prefix_q : tok_in.prefix;
			tag_out        <= take ? tag_q : tag_in;
		end
	end
endmodule

// File: design/ip_longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup: control, route count and the cell chain.
// Add, clear and rejected items: result in the cycle after the transfer.
// Lookup: the match token walks the chain one cell a cycle, and the result is registered from the chain's end.
// One item at a time; the next is taken the cycle after the previous result is transferred.
// Reset empties the table and clears the token chain; entry contents are not reset.
`timescale 1ns / 1ps
module ip_longest_prefix_route_lookup
	import lpm_pkg::*;
#(
	parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	localparam int CNT_W = $clog2(ROUTE_SLOTS + 1);
	localparam int IDX_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ROUTE_SLOTS);

	typedef enum logic [1:0] {IDLE, RUN, RESP} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             start_q;
	query_t           query_q;
	rsp_t             rsp_q;

	tok_t                 tok [ROUTE_SLOTS+1];
	logic [TAG_WIDTH-1:0] tags [ROUTE_SLOTS+1];

	logic       accept;
	logic [7:0] max_pfx;
	logic       add_ok;
	write_t     wr;
	logic       v4_ok;
	logic       v6_ok;

	assign accept  = req_valid && !req_stall;
	assign req_stall = (state_q != IDLE);
	assign max_pfx = req.addr_family ? IPV6_MAX_PFX : IPV4_MAX_PFX;
	assign add_ok  = (req.prefix_len <= max_pfx) && (count_q < FULL_CNT);
	assign v4_ok   = (req.version == VER_IPV4) && (req.packet_length >= IPV4_MIN_LEN);
	assign v6_ok   = (req.version == VER_IPV6) && (req.packet_length >= IPV6_MIN_LEN);

	always_comb begin
		wr.en     = accept && (req.operation == OP_ADD) && add_ok;
		wr.family = req.addr_family;
		wr.addr   = req.addr_family ? {req.addr_hi, req.addr_lo}
			: {req.addr_hi[63:32], 96'd0};
		wr.prefix = req.prefix_len;
	end

	assign tok[0].valid = start_q;
	assign tok[0].have  = 1'b0;
	assign tok[0].prefix = '0;
	assign tags[0]      = '0;

	for (genvar i = 0; i < ROUTE_SLOTS; i++) begin : g_cell
		lpm_cell #(
			.INDEX(i), .CNT_W(CNT_W), .IDX_W(IDX_W), .TAG_WIDTH(TAG_WIDTH)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .count(count_q),
			.wr(wr), .wr_idx(count_q[IDX_W-1:0]), .wr_tag(TAG_WIDTH'(req.eid_tag)),
			.query(query_q), .tok_in(tok[i]), .tag_in(tags[i]),
			.tok_out(tok[i+1]), .tag_out(tags[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			start_q <= 1'b0;
			query_q <= '0;
			rsp_q   <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= RESP;
						case (req.operation)
							OP_ADD: begin
								if (req.prefix_len > max_pfx) begin
									rsp_q <= '{status: ST_BAD_PFX, found_tag: '0,
										found_prefix_len: '0};
								end else if (count_q >= FULL_CNT) begin
									rsp_q <= '{status: ST_FULL, found_tag: '0,
										found_prefix_len: '0};
								end else begin
									rsp_q <= '{status: ST_ADDED, found_tag: '0,
										found_prefix_len: '0};
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_LOOKUP: begin
								if (v4_ok) begin
									query_q <= '{family: 1'b0,
										addr: {req.addr_hi[63:32], 96'd0}};
									start_q <= 1'b1;
									state_q <= RUN;
								end else if (v6_ok) begin
									query_q <= '{family: 1'b1,
										addr: {req.addr_hi, req.addr_lo}};
									start_q <= 1'b1;
									state_q <= RUN;
								end else begin
									rsp_q <= '{status: ST_REJECTED, found_tag: '0,
										found_prefix_len: '0};
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
								rsp_q <= '{status: ST_CLEARED, found_tag: '0,
									found_prefix_len: '0};
							end
							default: begin
								rsp_q <= '{status: ST_REJECTED, found_tag: '0,
									found_prefix_len: '0};
							end
						endcase
					end
				end
				RUN: begin
					if (tok[ROUTE_SLOTS].valid) begin
						state_q <= RESP;
						if (tok[ROUTE_SLOTS].have) begin
							rsp_q <= '{status: ST_FOUND,
								found_tag: OUT_TAG_W'(tags[ROUTE_SLOTS]),
								found_prefix_len: tok[ROUTE_SLOTS].prefix};
						end else begin
							rsp_q <= '{status: ST_NO_ROUTE, found_tag: '0,
								found_prefix_len: '0};
						end
					end
				end
				RESP: begin
					if (!rsp_stall) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = (state_q == RESP);
	assign rsp       = rsp_q;
endmodule
